[rtl/tws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg
// Shared sizes, operation codes and memory request types of the trie store.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int NODES    = 1024;
  localparam int ALPHABET = 26;
  localparam int SLOTS    = NODES * ALPHABET;

  localparam int NODE_W   = $clog2(NODES);
  localparam int FREE_W   = $clog2(NODES + 1);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int OP_W     = 2;
  localparam int LETTER_W = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } child_req_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic              wdata;
    logic              re;
    logic [NODE_W-1:0] raddr;
  } mark_req_t;

endpackage

[rtl/tws_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tws_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tws_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_ctrl
// Walk sequencer: clears the tables after reset, reads child pointers,
// allocates nodes, sets and reads end marks, and holds the result register.
// ----------------------------------------------------------------------------
module tws_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tws_pkg::OP_W-1:0]     operation,
  input  logic [tws_pkg::LETTER_W-1:0] letter,
  input  logic                         has_letter,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic                         status,
  output tws_pkg::child_req_t          child_req,
  input  logic [tws_pkg::NODE_W-1:0]   child_rdata,
  output tws_pkg::mark_req_t           mark_req,
  input  logic                         mark_rdata
);
  import tws_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;

  logic [2:0]        state;
  logic [SLOT_W-1:0] clr_cnt;
  logic [FREE_W-1:0] next_free;
  logic [NODE_W-1:0] current_node;
  logic              missed;
  logic              pool_full;
  logic [OP_W-1:0]   op_q;
  logic              last_q;
  logic [SLOT_W-1:0] slot_q;

  logic              accept;
  logic              letter_ok;
  logic [SLOT_W-1:0] slot_in;
  logic              out_free;
  logic              out_load;
  logic              is_insert;
  logic              alloc;
  logic              found_next;
  logic              status_next;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign letter_ok = has_letter && (32'(letter) < 32'(ALPHABET));
  assign slot_in   = SLOT_W'(current_node) * SLOT_W'(ALPHABET) + SLOT_W'(letter);
  assign out_free  = !out_valid || out_ready;
  assign is_insert = (op_q == OP_INSERT);
  assign alloc     = is_insert && !pool_full && (child_rdata == '0) &&
                     (next_free < FREE_W'(NODES));
  assign out_load  = out_free &&
                     (((state == S_FIN) && (op_q != OP_SEARCH)) || (state == S_MARK));

  // result of the word
  always_comb begin
    found_next  = !missed;
    status_next = 1'b0;
    if (state == S_MARK) begin
      found_next = !missed && mark_rdata;
    end else if (is_insert) begin
      found_next  = !pool_full;
      status_next = pool_full;
    end
  end

  // memory requests
  always_comb begin
    child_req = '0;
    mark_req  = '0;
    unique case (state)
      S_CLEAR: begin
        child_req.we    = 1'b1;
        child_req.waddr = clr_cnt;
        mark_req.we     = 1'b1;
        mark_req.waddr  = clr_cnt[NODE_W-1:0];
      end
      S_IDLE: begin
        child_req.re    = accept && letter_ok;
        child_req.raddr = slot_in;
      end
      S_WALK: begin
        child_req.we    = alloc;
        child_req.waddr = slot_q;
        child_req.wdata = next_free[NODE_W-1:0];
      end
      S_FIN: begin
        mark_req.we    = is_insert && !pool_full && out_free;
        mark_req.waddr = current_node;
        mark_req.wdata = 1'b1;
        mark_req.re    = (op_q == OP_SEARCH);
        mark_req.raddr = current_node;
      end
      S_MARK: begin
        mark_req.re = 1'b0;
      end
      default: begin
        child_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      next_free    <= FREE_W'(1);
      current_node <= '0;
      missed       <= 1'b0;
      pool_full    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SLOT_W'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (letter_ok) begin
              state <= S_WALK;
            end else if (last) begin
              state <= S_FIN;
            end
          end
        end
        S_WALK: begin
          if (is_insert) begin
            if (!pool_full) begin
              if (child_rdata != '0) begin
                current_node <= child_rdata;
              end else if (alloc) begin
                next_free    <= next_free + 1'b1;
                current_node <= next_free[NODE_W-1:0];
              end else begin
                pool_full <= 1'b1;
              end
            end
          end else if (!missed) begin
            if (child_rdata == '0) begin
              missed <= 1'b1;
            end else begin
              current_node <= child_rdata;
            end
          end
          state <= last_q ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (op_q == OP_SEARCH) begin
            state <= S_MARK;
          end else if (out_free) begin
            current_node <= '0;
            missed       <= 1'b0;
            pool_full    <= 1'b0;
            state        <= S_IDLE;
          end
        end
        S_MARK: begin
          if (out_free) begin
            current_node <= '0;
            missed       <= 1'b0;
            pool_full    <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // word fields and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      last_q <= last;
      slot_q <= slot_in;
    end
    if (out_load) begin
      found  <= found_next;
      status <= status_next;
    end
  end

`ifndef SYNTHESIS
  a_alloc_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && child_req.we) |=> next_free == FREE_W'($past(next_free) + 1'b1))
    else $error("next_free did not advance on node allocation");

  a_node_alloc: assert property (@(posedge clk) disable iff (rst)
    FREE_W'(current_node) < next_free)
    else $error("current node beyond allocated pool");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> !found)
    else $error("full status with found set");

  a_word_reset: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (current_node == '0 && !missed && !pool_full))
    else $error("walk state not cleared at end of word");
`endif

endmodule

[rtl/trie_word_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_word_store
// Prefix tree over lower-case words streamed one letter per word on the
// input channel; one result per word marked last.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   operation, letter, has_letter, last
//   out      out_valid / out_ready found, status
//
// a letter is a child pointer read, then a pointer update/alloc
// a last word adds state FIN, a last search also MARK (end mark memory read)
// after reset a clearing pass over the NODES*ALPHABET child slots (26624)
// zeroes the child table and end marks; in_ready stays low meanwhile
// a final result waits in its state while the output register is occupied
// ----------------------------------------------------------------------------
module trie_word_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tws_pkg::OP_W-1:0]     operation,
  input  logic [tws_pkg::LETTER_W-1:0] letter,
  input  logic                         has_letter,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic                         status
);
  import tws_pkg::*;

  child_req_t        child_req;
  mark_req_t         mark_req;
  logic [NODE_W-1:0] child_rdata;
  logic              mark_rdata;

  tws_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .letter      (letter),
    .has_letter  (has_letter),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .status      (status),
    .child_req   (child_req),
    .child_rdata (child_rdata),
    .mark_req    (mark_req),
    .mark_rdata  (mark_rdata)
  );

  tws_ram #(
    .DEPTH (SLOTS),
    .WIDTH (NODE_W)
  ) u_child_mem (
    .clk   (clk),
    .we    (child_req.we),
    .waddr (child_req.waddr),
    .wdata (child_req.wdata),
    .re    (child_req.re),
    .raddr (child_req.raddr),
    .rdata (child_rdata)
  );

  tws_ram #(
    .DEPTH (NODES),
    .WIDTH (1)
  ) u_mark_mem (
    .clk   (clk),
    .we    (mark_req.we),
    .waddr (mark_req.waddr),
    .wdata (mark_req.wdata),
    .re    (mark_req.re),
    .raddr (mark_req.raddr),
    .rdata (mark_rdata)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for trie_word_store. Keys are streamed one letter per
// word with random bursts and gaps while the result side stalls on its own
// pattern. A mirror of the prefix tree predicts every result, and each
// accepted result is compared with the oldest prediction. Directed keys
// cover empty keys, extreme and out-of-range letters, the spare operation
// and mixed operations; random traffic follows; the node pool is then filled
// until inserts are refused, and random traffic runs against the full pool.
// ----------------------------------------------------------------------------
module tb_top;
  import tws_pkg::*;

  localparam logic [OP_W-1:0]     OP_SPARE    = 2'd3;
  localparam int                  LETTER_MAX  = 2 ** LETTER_W - 1;
  localparam byte                 LETTER_A    = "a";
  localparam int                  STALL_LIMIT = 100000;
  localparam int                  DRAIN_WAIT  = 16;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_t;

  class trie_mirror;
    typedef struct packed {
      logic found;
      logic status;
    } answer_t;

    logic [NODE_W-1:0] child_of [SLOTS];
    bit                word_end [NODES];
    int unsigned       next_node;
    int unsigned       cur_node;
    bit                lookup_missed;
    bit                pool_out;
    answer_t           answers[$];
    int                mismatches;
    int                n_results;
    int                n_found;
    int                n_refused;

    function new();
      foreach (child_of[i]) child_of[i] = '0;
      foreach (word_end[i]) word_end[i] = 1'b0;
      next_node     = 1;
      cur_node      = 0;
      lookup_missed = 1'b0;
      pool_out      = 1'b0;
      mismatches    = 0;
      n_results     = 0;
      n_found       = 0;
      n_refused     = 0;
    endfunction

    task report(string what);
      mismatches++;
      $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task note_word(logic [OP_W-1:0] op, logic [LETTER_W-1:0] ltr, logic has, logic lst);
      int unsigned idx;
      answer_t     want;
      if (has && ltr < ALPHABET) begin
        idx = cur_node * ALPHABET + ltr;
        if (op == OP_INSERT) begin
          if (!pool_out) begin
            if (child_of[idx] == '0 && next_node >= NODES) begin
              pool_out = 1'b1;
            end else begin
              if (child_of[idx] == '0) begin
                child_of[idx] = next_node[NODE_W-1:0];
                next_node++;
              end
              cur_node = child_of[idx];
            end
          end
        end else if (!lookup_missed) begin
          if (child_of[idx] == '0) begin
            lookup_missed = 1'b1;
          end else begin
            cur_node = child_of[idx];
          end
        end
      end
      if (!lst) return;
      want = '0;
      if (op == OP_INSERT) begin
        if (pool_out) begin
          want.status = 1'b1;
        end else begin
          word_end[cur_node] = 1'b1;
          want.found = 1'b1;
        end
      end else if (op == OP_SEARCH) begin
        want.found = !lookup_missed && word_end[cur_node];
      end else begin
        want.found = !lookup_missed;
      end
      answers.push_back(want);
      cur_node      = 0;
      lookup_missed = 1'b0;
      pool_out      = 1'b0;
    endtask

    task check_answer(logic got_found, logic got_status);
      answer_t want;
      if (answers.size() == 0) begin
        report($sformatf("result found=%b status=%b with none pending", got_found, got_status));
        return;
      end
      want = answers.pop_front();
      n_results++;
      if (want.found) n_found++;
      if (want.status) n_refused++;
      if (got_found !== want.found) begin
        report($sformatf("found %b, predicted %b", got_found, want.found));
      end
      if (got_status !== want.status) begin
        report($sformatf("status %b, predicted %b", got_status, want.status));
      end
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     operation;
  logic [LETTER_W-1:0] letter;
  logic                has_letter;
  logic                last;
  logic                out_valid;
  logic                out_ready;
  logic                found;
  logic                status;

  trie_mirror mirror;
  string      known_keys[$];
  int         items_sent;
  int         burst_left;
  int         idle_cycles = 0;

  trie_word_store uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .letter     (letter),
    .has_letter (has_letter),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .status     (status)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // monitor: results are checked before the word of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) mirror.check_answer(found, status);
      if (in_valid && in_ready) mirror.note_word(operation, letter, has_letter, last);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side stall pattern
  initial begin
    rx_mode_t mode;
    int       phase_left;
    int       hold;
    phase_left = 0;
    hold = 0;
    mode = RX_OPEN;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      case (mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= (phase_left % 4 == 0);
        default: begin
          if (hold == 0) hold = $urandom_range(1, 15);
          hold--;
          out_ready <= (hold == 0);
        end
      endcase
    end
  end

  task automatic drive_item(logic [OP_W-1:0] op, logic [LETTER_W-1:0] ltr, logic has,
                            logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 12);
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    operation  <= op;
    letter     <= ltr;
    has_letter <= has;
    last       <= lst;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if ((has && ltr < ALPHABET) || lst) items_sent++;
  endtask

  // one key, one letter per word; noise adds ignored words and operation switches
  task automatic send_key(logic [OP_W-1:0] op, string key, bit noisy);
    logic [OP_W-1:0] item_op;
    logic            junk_has;
    if (key.len() == 0) begin
      drive_item(op, LETTER_W'($urandom_range(0, LETTER_MAX)), 1'b0, 1'b1);
      return;
    end
    for (int i = 0; i < key.len(); i++) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        junk_has = 1'($urandom_range(0, 1));
        drive_item(op, LETTER_W'(junk_has ? $urandom_range(ALPHABET, LETTER_MAX)
                                          : $urandom_range(0, LETTER_MAX)),
                   junk_has, 1'b0);
      end
      item_op = op;
      if (noisy && i != key.len() - 1 && $urandom_range(0, 11) == 0) begin
        item_op = OP_W'($urandom_range(0, 3));
      end
      drive_item(item_op, LETTER_W'(key[i] - LETTER_A), 1'b1, i == key.len() - 1);
    end
  endtask

  function automatic string random_key(int max_len, bit spread);
    string key;
    int    len;
    int    ltr;
    key = "";
    len = $urandom_range(1, max_len);
    for (int i = 0; i < len; i++) begin
      ltr = (spread || $urandom_range(0, 3) == 0) ? $urandom_range(0, ALPHABET - 1)
                                                  : $urandom_range(0, 4);
      key = $sformatf("%s%c", key, LETTER_A + ltr);
    end
    return key;
  endfunction

  task automatic settle_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.answers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic random_traffic(int count);
    int              stop_at;
    int              pick;
    logic [OP_W-1:0] op;
    string           key;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      op = pick < 34 ? OP_INSERT : pick < 67 ? OP_SEARCH : pick < 95 ? OP_PREFIX : OP_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        key = "";
      end else if (known_keys.size() == 0 || pick < 40 || (op == OP_INSERT && pick < 75)) begin
        key = random_key($urandom_range(0, 7) == 0 ? 12 : 5, 1'b0);
      end else begin
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
        if (pick < 60 && key.len() > 1) begin
          key = key.substr(0, $urandom_range(0, key.len() - 2));
        end else if (pick < 70) begin
          key = {key, random_key(3, 1'b0)};
        end
      end
      if (op == OP_INSERT) known_keys.push_back(key);
      send_key(op, key, 1'b1);
      if ($urandom_range(0, 199) == 0) settle_results();
    end
  endtask

  initial begin
    string key;
    mirror      = new();
    items_sent  = 0;
    burst_left  = 0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    operation  <= OP_INSERT;
    letter     <= '0;
    has_letter <= 1'b0;
    last       <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty keys against an empty tree, then the root as a stored key
    send_key(OP_SEARCH, "", 1'b0);
    send_key(OP_PREFIX, "", 1'b0);
    send_key(OP_INSERT, "", 1'b0);
    send_key(OP_SEARCH, "", 1'b0);
    send_key(OP_INSERT, "z", 1'b0);
    send_key(OP_SEARCH, "z", 1'b0);
    send_key(OP_SPARE, "z", 1'b0);
    send_key(OP_SEARCH, "y", 1'b0);
    send_key(OP_PREFIX, "zz", 1'b0);
    // out-of-range letter and a letterless word inside an insert
    drive_item(OP_INSERT, LETTER_W'(LETTER_MAX), 1'b1, 1'b0);
    drive_item(OP_INSERT, LETTER_W'(ALPHABET), 1'b1, 1'b0);
    drive_item(OP_INSERT, LETTER_W'(LETTER_MAX), 1'b0, 1'b0);
    drive_item(OP_INSERT, LETTER_W'("a" - LETTER_A), 1'b1, 1'b1);
    send_key(OP_SEARCH, "a", 1'b0);
    // insert continues from the root after a lookup miss
    drive_item(OP_SEARCH, LETTER_W'("q" - LETTER_A), 1'b1, 1'b0);
    drive_item(OP_INSERT, LETTER_W'("b" - LETTER_A), 1'b1, 1'b1);
    send_key(OP_SEARCH, "b", 1'b0);
    send_key(OP_SEARCH, "qb", 1'b0);
    send_key(OP_PREFIX, "a", 1'b0);
    known_keys.push_back("z");
    known_keys.push_back("a");
    known_keys.push_back("b");
    settle_results();

    random_traffic(200);
    settle_results();

    // use up the node pool with long keys
    while (mirror.next_node < NODES) send_key(OP_INSERT, random_key(40, 1'b1), 1'b0);
    key = random_key(12, 1'b1);
    send_key(OP_INSERT, key, 1'b0);
    send_key(OP_SEARCH, key, 1'b0);
    send_key(OP_PREFIX, key.substr(0, 0), 1'b0);
    send_key(OP_INSERT, "z", 1'b0);
    send_key(OP_INSERT, "", 1'b0);
    send_key(OP_SEARCH, "z", 1'b0);
    settle_results();

    random_traffic(50);

    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.answers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d letter and end words sent, %0d results checked, %0d of them hits",
             items_sent, mirror.n_results, mirror.n_found);
    $display("%0d inserts refused on a full pool, %0d nodes allocated, %0d mismatches",
             mirror.n_refused, mirror.next_node, mirror.mismatches);
    if (mirror.mismatches == 0 && mirror.answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
